[design/ivfpq_pkg.sv]
// Shared types and constants of the IVF product-quantization encoder.
// Depends on nothing; every other design file refers to it by scoped names.
package ivfpq_pkg;

   localparam int VECTOR_DIM = 16;
   localparam int CLUSTERS   = 16;
   localparam int SUBSPACES  = 4;
   localparam int SLICE      = VECTOR_DIM / SUBSPACES;
   localparam int ELEM_W     = 16;
   localparam int IDX_W      = 4;
   localparam int SUM_W      = 40;

   // Request type codes.
   localparam logic [1:0] REQ_LOAD_COARSE = 2'd0;
   localparam logic [1:0] REQ_LOAD_RESID  = 2'd1;
   localparam logic [1:0] REQ_SAMPLE      = 2'd2;

   // Search phase carried by a token through the chain.
   localparam logic PHASE_COARSE = 1'b0;
   localparam logic PHASE_RESID  = 1'b1;

   // One centroid token travelling along the cell chain.
   typedef struct packed {
      logic             valid;
      logic             phase;
      logic [IDX_W-1:0] idx;
   } token_type;

   // Table and sample writes broadcast to all cells.
   typedef struct packed {
      logic              wr_coarse;
      logic              wr_resid;
      logic              wr_sample;
      logic [IDX_W-1:0]  entry;
      logic [IDX_W-1:0]  element;
      logic [ELEM_W-1:0] value;
   } load_type;

endpackage

[design/ivfpq_cell.sv]
// One dimension cell of the distance chain: holds its column of both tables,
// its sample element and residual, and adds its squared difference to the
// running sum. Depends on ivfpq_pkg.
module ivfpq_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ivfpq_pkg::IDX_W-1:0]   cell_index,
   input  ivfpq_pkg::load_type           load,
   input  logic                          resid_load,
   input  logic [ivfpq_pkg::IDX_W-1:0]   best_idx,
   input  ivfpq_pkg::token_type          tok_in,
   input  logic [ivfpq_pkg::SUM_W-1:0]   sum_in,
   output ivfpq_pkg::token_type          tok_out,
   output logic [ivfpq_pkg::SUM_W-1:0]   sum_out
);

   logic signed [ivfpq_pkg::ELEM_W-1:0] coarse_col [ivfpq_pkg::CLUSTERS];
   logic signed [ivfpq_pkg::ELEM_W-1:0] resid_col  [ivfpq_pkg::CLUSTERS];
   logic signed [ivfpq_pkg::ELEM_W-1:0] sample_ff;
   logic signed [ivfpq_pkg::ELEM_W:0]   resid_ff;
   ivfpq_pkg::token_type                tok_ff;
   logic [ivfpq_pkg::SUM_W-1:0]         sum_ff;
   logic [ivfpq_pkg::IDX_W-1:0]         coarse_addr;
   logic signed [ivfpq_pkg::ELEM_W-1:0] coarse_rd;
   logic signed [ivfpq_pkg::ELEM_W+1:0] diff;
   logic signed [2*ivfpq_pkg::ELEM_W+3:0] square;
   logic                                slice_start;
   logic [ivfpq_pkg::SUM_W-1:0]         sum_base;
   logic [ivfpq_pkg::SUM_W-1:0]         sum_in_next;

   // One read port on the coarse column, shared by search and residual forming.
   assign coarse_addr = resid_load ? best_idx : tok_in.idx;
   assign coarse_rd   = coarse_col[coarse_addr];

   // Table and sample writes addressed to this dimension.
   always_ff @(posedge clock) begin
      if (load.element == cell_index) begin
         if (load.wr_coarse) begin
            coarse_col[load.entry] <= load.value;
         end
         if (load.wr_resid) begin
            resid_col[load.entry] <= load.value;
         end
         if (load.wr_sample) begin
            sample_ff <= load.value;
         end
      end
      if (resid_load) begin
         resid_ff <= (ivfpq_pkg::ELEM_W+1)'(sample_ff) - (ivfpq_pkg::ELEM_W+1)'(coarse_rd);
      end
   end

   // Squared difference for the token's centroid.
   always_comb begin
      if (tok_in.phase == ivfpq_pkg::PHASE_COARSE) begin
         diff = (ivfpq_pkg::ELEM_W+2)'(sample_ff) - (ivfpq_pkg::ELEM_W+2)'(coarse_rd);
      end else begin
         diff = (ivfpq_pkg::ELEM_W+2)'(resid_ff)
                - (ivfpq_pkg::ELEM_W+2)'(resid_col[tok_in.idx]);
      end
      square = (2*ivfpq_pkg::ELEM_W+4)'(diff) * (2*ivfpq_pkg::ELEM_W+4)'(diff);
   end

   // In the residual pass a subspace sum restarts at the first dimension of each slice.
   assign slice_start = (cell_index % ivfpq_pkg::IDX_W'(ivfpq_pkg::SLICE)) == '0;
   assign sum_base    = (tok_in.phase == ivfpq_pkg::PHASE_RESID && slice_start) ? '0 : sum_in;
   assign sum_in_next = sum_base + ivfpq_pkg::SUM_W'(unsigned'(square));

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
      sum_ff <= sum_in_next;
   end

   assign tok_out = tok_ff;
   assign sum_out = sum_ff;

endmodule

[design/ivf_pq_vector_encoder.sv]
// Top level of the IVF product-quantization encoder: sequencer, cell chain,
// nearest-centroid trackers and result register. Depends on ivfpq_pkg, ivfpq_cell.

// The final sample of a vector starts an encode that runs through a chain of
// 16 dimension cells: one centroid enters the chain per cycle, first for the
// coarse pass and then, after the residual is formed, for the residual pass.
// Requests are stalled for the whole encode; results come out in order
// coarse code first, then one per subspace, the last flagged by last_code.
module ivf_pq_vector_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [3:0]  req_entry_index,
   input  logic [3:0]  req_element_index,
   input  logic signed [15:0] req_elem_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_vector_number,
   output logic [2:0]  rsp_code_slot,
   output logic [3:0]  rsp_code_value,
   output logic        rsp_last_code,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_clusters_in_use
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_C_ISSUE = 3'd1;
   localparam logic [2:0] ST_C_WAIT  = 3'd2;
   localparam logic [2:0] ST_R_LOAD  = 3'd3;
   localparam logic [2:0] ST_R_ISSUE = 3'd4;
   localparam logic [2:0] ST_R_WAIT  = 3'd5;
   localparam logic [2:0] ST_EMIT    = 3'd6;

   localparam int NSLOT = ivfpq_pkg::SUBSPACES + 1;

   logic [2:0]                        state_ff, state_in;
   logic [ivfpq_pkg::IDX_W-1:0]       last_idx_ff;
   logic [ivfpq_pkg::IDX_W-1:0]       issue_ff, issue_in;
   logic [2:0]                        slot_ff, slot_in;
   logic [31:0]                       count_ff;
   logic                              rsp_valid_ff;
   logic [31:0]                       rsp_number_ff;
   logic [2:0]                        rsp_slot_ff;
   logic [3:0]                        rsp_code_ff;
   logic                              rsp_last_ff;
   logic [ivfpq_pkg::SUM_W-1:0]       best_d_ff   [NSLOT];
   logic [ivfpq_pkg::IDX_W-1:0]       best_idx_ff [NSLOT];
   logic                              req_acc;
   logic                              out_free;
   ivfpq_pkg::load_type               load;
   ivfpq_pkg::token_type              tok   [ivfpq_pkg::VECTOR_DIM+1];
   logic [ivfpq_pkg::SUM_W-1:0]       sum   [ivfpq_pkg::VECTOR_DIM+1];
   logic                              coarse_done;
   logic                              resid_done;

   assign req_stall = state_ff != ST_IDLE;
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Request decode into table and sample writes.
   always_comb begin
      load.wr_coarse = req_acc && req_type == ivfpq_pkg::REQ_LOAD_COARSE;
      load.wr_resid  = req_acc && req_type == ivfpq_pkg::REQ_LOAD_RESID;
      load.wr_sample = req_acc && req_type == ivfpq_pkg::REQ_SAMPLE;
      load.entry     = req_entry_index;
      load.element   = req_element_index;
      load.value     = req_elem_value;
   end

   // Token source at the head of the chain.
   always_comb begin
      tok[0].valid = state_ff == ST_C_ISSUE || state_ff == ST_R_ISSUE;
      tok[0].phase = (state_ff == ST_R_ISSUE) ? ivfpq_pkg::PHASE_RESID
                                              : ivfpq_pkg::PHASE_COARSE;
      tok[0].idx   = issue_ff;
      sum[0]       = '0;
   end

   // The chain of dimension cells.
   for (genvar j = 0; j < ivfpq_pkg::VECTOR_DIM; j++) begin : g_cell
      ivfpq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (ivfpq_pkg::IDX_W'(j)),
         .load       (load),
         .resid_load (state_ff == ST_R_LOAD),
         .best_idx   (best_idx_ff[0]),
         .tok_in     (tok[j]),
         .sum_in     (sum[j]),
         .tok_out    (tok[j+1]),
         .sum_out    (sum[j+1])
      );
   end

   assign coarse_done = tok[ivfpq_pkg::VECTOR_DIM].valid
                        && tok[ivfpq_pkg::VECTOR_DIM].phase == ivfpq_pkg::PHASE_COARSE
                        && tok[ivfpq_pkg::VECTOR_DIM].idx == last_idx_ff;
   assign resid_done  = tok[ivfpq_pkg::VECTOR_DIM].valid
                        && tok[ivfpq_pkg::VECTOR_DIM].phase == ivfpq_pkg::PHASE_RESID
                        && tok[ivfpq_pkg::VECTOR_DIM].idx == last_idx_ff;

   // Nearest-centroid trackers: the coarse sum leaves the end of the chain,
   // each subspace sum leaves the last cell of its slice. Strict less keeps
   // the lowest index on ties.
   always_ff @(posedge clock) begin
      if (tok[ivfpq_pkg::VECTOR_DIM].valid
          && tok[ivfpq_pkg::VECTOR_DIM].phase == ivfpq_pkg::PHASE_COARSE
          && (tok[ivfpq_pkg::VECTOR_DIM].idx == '0
              || sum[ivfpq_pkg::VECTOR_DIM] < best_d_ff[0])) begin
         best_d_ff[0]   <= sum[ivfpq_pkg::VECTOR_DIM];
         best_idx_ff[0] <= tok[ivfpq_pkg::VECTOR_DIM].idx;
      end
      for (int s = 1; s < NSLOT; s++) begin
         if (tok[s*ivfpq_pkg::SLICE].valid
             && tok[s*ivfpq_pkg::SLICE].phase == ivfpq_pkg::PHASE_RESID
             && (tok[s*ivfpq_pkg::SLICE].idx == '0
                 || sum[s*ivfpq_pkg::SLICE] < best_d_ff[s])) begin
            best_d_ff[s]   <= sum[s*ivfpq_pkg::SLICE];
            best_idx_ff[s] <= tok[s*ivfpq_pkg::SLICE].idx;
         end
      end
   end

   // Encode sequencer.
   always_comb begin
      state_in = state_ff;
      issue_in = issue_ff;
      slot_in  = slot_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (load.wr_sample
                && req_element_index == ivfpq_pkg::IDX_W'(ivfpq_pkg::VECTOR_DIM-1)) begin
               state_in = ST_C_ISSUE;
               issue_in = '0;
            end
         end
         ST_C_ISSUE: begin
            issue_in = issue_ff + 1'b1;
            if (issue_ff == last_idx_ff) begin
               state_in = ST_C_WAIT;
            end
         end
         ST_C_WAIT: begin
            if (coarse_done) begin
               state_in = ST_R_LOAD;
            end
         end
         ST_R_LOAD: begin
            state_in = ST_R_ISSUE;
            issue_in = '0;
         end
         ST_R_ISSUE: begin
            issue_in = issue_ff + 1'b1;
            if (issue_ff == last_idx_ff) begin
               state_in = ST_R_WAIT;
            end
         end
         ST_R_WAIT: begin
            if (resid_done) begin
               state_in = ST_EMIT;
               slot_in  = '0;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               slot_in = slot_ff + 1'b1;
               if (slot_ff == 3'(ivfpq_pkg::SUBSPACES)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         issue_ff    <= '0;
         slot_ff     <= '0;
         count_ff    <= '0;
         last_idx_ff <= ivfpq_pkg::IDX_W'(ivfpq_pkg::CLUSTERS-1);
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
         slot_ff  <= slot_in;
         if (state_ff == ST_EMIT && out_free
             && slot_ff == 3'(ivfpq_pkg::SUBSPACES)) begin
            count_ff <= count_ff + 1'b1;
         end
         // Clamp the cluster count to 1..CLUSTERS and keep the last index.
         if (csr_valid && csr_ready) begin
            if (csr_clusters_in_use == '0) begin
               last_idx_ff <= '0;
            end else if (csr_clusters_in_use > 5'(ivfpq_pkg::CLUSTERS)) begin
               last_idx_ff <= ivfpq_pkg::IDX_W'(ivfpq_pkg::CLUSTERS-1);
            end else begin
               last_idx_ff <= ivfpq_pkg::IDX_W'(csr_clusters_in_use - 5'd1);
            end
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_EMIT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == ST_EMIT && out_free) begin
         rsp_number_ff <= count_ff;
         rsp_slot_ff   <= slot_ff;
         rsp_code_ff   <= best_idx_ff[slot_ff];
         rsp_last_ff   <= slot_ff == 3'(ivfpq_pkg::SUBSPACES);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_vector_number = rsp_number_ff;
   assign rsp_code_slot     = rsp_slot_ff;
   assign rsp_code_value    = rsp_code_ff;
   assign rsp_last_code     = rsp_last_ff;

   // The last code of a vector is always the final subspace slot.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_slot_ff == 3'(ivfpq_pkg::SUBSPACES))
      else $error("last code on a slot other than the final subspace");

   // No residual token may leave the chain while the coarse pass is still issuing.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_C_ISSUE |-> !(tok[ivfpq_pkg::VECTOR_DIM].valid
                                   && tok[ivfpq_pkg::VECTOR_DIM].phase
                                      == ivfpq_pkg::PHASE_RESID))
      else $error("residual token in flight during coarse pass");

   // The chosen coarse centroid lies within the searched range.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> best_idx_ff[0] <= last_idx_ff)
      else $error("coarse code beyond active cluster count");

   // A result appears only while emitting or while holding a stalled one.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT)
      else $error("result raised outside the emit state");

endmodule

[bench/ivf_pq_vector_encoder_checker.sv]
// Checker for the IVF product-quantization encoder: watches the request, result
// and register channels, predicts the codes of every vector and compares them.
// Depends on ivfpq_pkg for table sizes and request type codes.
module ivf_pq_vector_encoder_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [3:0]  req_entry_index,
   input  logic [3:0]  req_element_index,
   input  logic signed [15:0] req_elem_value,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_vector_number,
   input  logic [2:0]  rsp_code_slot,
   input  logic [3:0]  rsp_code_value,
   input  logic        rsp_last_code,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [4:0]  csr_clusters_in_use,
   output int          fail_count,
   output int          codes_pending
);

   typedef struct packed {
      logic [31:0] vector_number;
      logic [2:0]  code_slot;
      logic [3:0]  code_value;
      logic        last_code;
   } code_type;

   logic signed [15:0] coarse_mem [ivfpq_pkg::CLUSTERS*ivfpq_pkg::VECTOR_DIM];
   logic signed [15:0] resid_mem  [ivfpq_pkg::CLUSTERS*ivfpq_pkg::VECTOR_DIM];
   logic signed [15:0] sample_mem [ivfpq_pkg::VECTOR_DIM];
   logic [31:0]        vec_count;
   logic [4:0]         cluster_reg;
   code_type           expected_codes [$];

   assign codes_pending = expected_codes.size();

   // Searches both passes for the buffered vector and queues its codes.
   task automatic encode_vector();
      int unsigned nc, best;
      longint d, bestd, df;
      longint resid [ivfpq_pkg::VECTOR_DIM];
      code_type cd;
      nc = (cluster_reg == 0) ? 1 : ((cluster_reg > ivfpq_pkg::CLUSTERS)
                                     ? ivfpq_pkg::CLUSTERS : cluster_reg);
      best = 0;
      bestd = 0;
      for (int c = 0; c < nc; c++) begin
         d = 0;
         for (int j = 0; j < ivfpq_pkg::VECTOR_DIM; j++) begin
            df = longint'(sample_mem[j])
                 - longint'(coarse_mem[c*ivfpq_pkg::VECTOR_DIM+j]);
            d += df * df;
         end
         if (c == 0 || d < bestd) begin
            bestd = d;
            best = c;
         end
      end
      for (int j = 0; j < ivfpq_pkg::VECTOR_DIM; j++)
         resid[j] = longint'(sample_mem[j])
                    - longint'(coarse_mem[best*ivfpq_pkg::VECTOR_DIM+j]);
      cd = '{vec_count, 3'd0, best[3:0], 1'b0};
      expected_codes = {expected_codes, cd};
      for (int s = 0; s < ivfpq_pkg::SUBSPACES; s++) begin
         best = 0;
         bestd = 0;
         for (int c = 0; c < nc; c++) begin
            d = 0;
            for (int j = 0; j < ivfpq_pkg::SLICE; j++) begin
               df = resid[s*ivfpq_pkg::SLICE+j]
                    - longint'(resid_mem[c*ivfpq_pkg::VECTOR_DIM+s*ivfpq_pkg::SLICE+j]);
               d += df * df;
            end
            if (c == 0 || d < bestd) begin
               bestd = d;
               best = c;
            end
         end
         cd = '{vec_count, 3'(s + 1), best[3:0], (s == ivfpq_pkg::SUBSPACES - 1)};
         expected_codes = {expected_codes, cd};
      end
      vec_count++;
   endtask

   // Predict on accepted requests and register writes, compare accepted codes.
   always @(posedge clock) begin
      code_type exp_c;
      if (reset) begin
         vec_count   = 0;
         cluster_reg = 5'd16;
         fail_count  <= 0;
         expected_codes.delete();
      end else begin
         if (csr_valid && csr_ready)
            cluster_reg = csr_clusters_in_use;
         if (req_valid && !req_stall) begin
            if (req_type == ivfpq_pkg::REQ_LOAD_COARSE)
               coarse_mem[req_entry_index*ivfpq_pkg::VECTOR_DIM+req_element_index] =
                  req_elem_value;
            else if (req_type == ivfpq_pkg::REQ_LOAD_RESID)
               resid_mem[req_entry_index*ivfpq_pkg::VECTOR_DIM+req_element_index] =
                  req_elem_value;
            else if (req_type == ivfpq_pkg::REQ_SAMPLE) begin
               sample_mem[req_element_index] = req_elem_value;
               if (req_element_index == ivfpq_pkg::VECTOR_DIM - 1)
                  encode_vector();
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_codes.size() == 0) begin
               $error("unexpected code: vector %0d slot %0d", rsp_vector_number,
                      rsp_code_slot);
               fail_count <= fail_count + 1;
            end else begin
               exp_c = expected_codes.pop_front();
               if (exp_c.vector_number !== rsp_vector_number ||
                   exp_c.code_slot !== rsp_code_slot ||
                   exp_c.code_value !== rsp_code_value ||
                   exp_c.last_code !== rsp_last_code)
                  fail_count <= fail_count + 1;
               if (exp_c.vector_number !== rsp_vector_number)
                  $error("vector_number: expected %0d, got %0d",
                         exp_c.vector_number, rsp_vector_number);
               if (exp_c.code_slot !== rsp_code_slot)
                  $error("code_slot: expected %0d, got %0d", exp_c.code_slot,
                         rsp_code_slot);
               if (exp_c.code_value !== rsp_code_value)
                  $error("code_value: expected %0d, got %0d", exp_c.code_value,
                         rsp_code_value);
               if (exp_c.last_code !== rsp_last_code)
                  $error("last_code: expected %0d, got %0d", exp_c.last_code,
                         rsp_last_code);
            end
         end
      end
   end
endmodule

[bench/ivf_pq_vector_encoder_tb.sv]
// Top of the encoder regression: clock, reset, request and register stimulus,
// result-side stalls and the verdict. Depends on ivfpq_pkg, the encoder and
// ivf_pq_vector_encoder_checker.
module ivf_pq_vector_encoder_tb;

   // Request type that the block ignores.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = ivfpq_pkg::REQ_SAMPLE;
   logic [3:0]  req_entry_index = '0;
   logic [3:0]  req_element_index = '0;
   logic signed [15:0] req_elem_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_vector_number;
   logic [2:0]  rsp_code_slot;
   logic [3:0]  rsp_code_value;
   logic        rsp_last_code;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_clusters_in_use = 5'd16;
   int          fail_count;
   int          codes_pending;
   bit          hold_results = 1'b0;

   ivf_pq_vector_encoder dut (.*);

   ivf_pq_vector_encoder_checker checker_i (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mostly short gaps with an occasional long one.
   function automatic int gap_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // Offers one request and holds it until accepted, then a random gap unless no_gap is set.
   task automatic send_request(input logic [1:0] kind, input int entry, input int element,
                               input logic signed [15:0] value, input bit no_gap = 0);
      int g;
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_entry_index   <= entry[3:0];
      req_element_index <= element[3:0];
      req_elem_value    <= value;
      do @(posedge clock); while (req_stall);
      g = no_gap ? 0 : gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   function automatic logic signed [15:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Loads every element of the first centroids of both tables, so that no
   // search touches an unwritten entry.
   task automatic load_tables(input bit extremes, input int count);
      for (int c = 0; c < count; c++)
         for (int j = 0; j < ivfpq_pkg::VECTOR_DIM; j++) begin
            send_request(ivfpq_pkg::REQ_LOAD_COARSE, c, j,
                         extremes ? ((c % 2) ? 16'sh7fff : 16'sh8000) : rand_value(), 1);
            send_request(ivfpq_pkg::REQ_LOAD_RESID, c, j,
                         extremes ? 16'sh0000 : rand_value(), 1);
         end
   endtask

   task automatic send_vector(input bit noisy);
      for (int j = 0; j < ivfpq_pkg::VECTOR_DIM; j++) begin
         if (noisy && $urandom_range(0, 7) == 0)
            send_request(REQ_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                         rand_value());
         send_request(ivfpq_pkg::REQ_SAMPLE, $urandom_range(0, 15), j, rand_value());
      end
   endtask

   // Waits for all codes, then for the encode pipeline to go quiet.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (codes_pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_clusters(input logic [4:0] value);
      csr_valid           <= 1'b1;
      csr_clusters_in_use <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Result-side stalls, with one long hold-off on request.
   always @(posedge clock) begin
      int g;
      if (hold_results) begin
         rsp_stall <= 1'b1;
         repeat (400) @(posedge clock);
         hold_results = 1'b0;
      end
      g = gap_len();
      rsp_stall <= (g > 0);
      if (g > 1) repeat (g - 1) @(posedge clock);
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: two centroids at equal distance force ties on
      // all-extreme samples, then an ignored request and a re-encode.
      write_clusters(5'd2);
      load_tables(1, 2);
      for (int j = 0; j < ivfpq_pkg::VECTOR_DIM; j++)
         send_request(ivfpq_pkg::REQ_SAMPLE, 0, j, (j % 2) ? 16'sh7fff : 16'sh8000);
      send_request(REQ_UNUSED, 15, 15, 16'sh7fff);
      send_request(ivfpq_pkg::REQ_SAMPLE, 15, 3, 16'sh0000);
      send_request(ivfpq_pkg::REQ_SAMPLE, 0, 15, 16'sh8000);
      drain();

      // Random tables; a cluster count of zero searches one centroid.
      write_clusters(5'd0);
      load_tables(0, 2);
      send_vector(1);
      drain();

      // Two vectors under a long result hold-off, so the input stalls.
      write_clusters(5'd2);
      hold_results = 1'b1;
      send_vector(1);
      send_vector(0);
      drain();

      if (fail_count == 0)
         $display("ivf_pq_vector_encoder regression: pass");
      else
         $display("ivf_pq_vector_encoder regression: fail");
      $finish;
   end

   initial begin
      #2000000;
      $display("ivf_pq_vector_encoder regression: fail");
      $finish;
   end
endmodule
